// File: design/ase_pkg.sv
`timescale 1ns / 1ps

package ase_pkg;

    localparam int unsigned BUF_W      = 17;
    localparam int unsigned CNT_W      = 5;
    localparam int unsigned FRAME_BITS = 10;
    localparam int unsigned DATA_W     = 8;

    localparam logic [0:0] OP_BYTE = 1'b0;
    localparam logic [0:0] OP_BIT  = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] char_out;
        logic              frame_error;
    } t_frame;

    typedef struct packed {
        logic   valid;
        t_frame frame;
    } t_frame_beat;

endpackage

// File: design/ase_if.sv
`timescale 1ns / 1ps

interface ase_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;
    logic       line_bit;

    modport source (output valid, output operation, output data_byte, output line_bit,
                    input ready);
    modport sink   (input valid, input operation, input data_byte, input line_bit,
                    output ready);
endinterface

interface ase_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       frame_error;

    modport source (output valid, output char_out, output frame_error, input ready);
    modport sink   (input valid, input char_out, input frame_error, output ready);
endinterface

// File: design/async_serial_frame_extractor.sv
`timescale 1ns / 1ps
// An accepted item is shifted into the buffer, eight bits for a byte write or one for a
// line bit; idle bits are then dropped from the top of the buffer (up to 7 ahead of a frame),
// and a complete frame is then registered in the output stage. A new item is accepted only
// while idle: not while the last one is shifted or trimmed, nor while a complete frame
// waits for the output register, which stays full while its frame waits for the sink.
// Reset (synchronous, active low): buffer all ones, bit count zero, output empty.
module async_serial_frame_extractor
    import ase_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    ase_in_if.sink   i_in,
    ase_out_if.source o_out
);

    logic        w_start;
    logic        w_idle;
    logic        w_push_ok;
    t_frame_beat w_frame;
    t_frame      w_out;

    assign i_in.ready = w_idle;
    assign w_start    = i_in.valid && w_idle;

    ase_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_operation (i_in.operation),
        .i_data_byte (i_in.data_byte),
        .i_line_bit  (i_in.line_bit),
        .i_push_ok   (w_push_ok),
        .o_idle      (w_idle),
        .o_frame     (w_frame)
    );

    ase_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_frame   (w_frame),
        .i_ready   (o_out.ready),
        .o_push_ok (w_push_ok),
        .o_valid   (o_out.valid),
        .o_frame   (w_out)
    );

    assign o_out.char_out    = w_out.char_out;
    assign o_out.frame_error = w_out.frame_error;

endmodule

// File: design/ase_core.sv
`timescale 1ns / 1ps

module ase_core
    import ase_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_operation,
    input  logic [DATA_W-1:0] i_data_byte,
    input  logic              i_line_bit,
    input  logic              i_push_ok,
    output logic              o_idle,
    output t_frame_beat       o_frame
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHIFT = 2'd1;
    localparam logic [1:0] ST_TRIM  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [BUF_W-1:0]  r_buf, n_buf;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DATA_W-1:0] r_sreg, n_sreg;
    logic [2:0]        r_left, n_left;

    logic              w_ge10;
    logic              w_top;
    logic              w_stop;
    logic [DATA_W-1:0] w_char;
    logic [CNT_W-1:0]  w_top_idx;
    logic [CNT_W-1:0]  w_stop_idx;

    assign w_ge10     = (r_cnt >= CNT_W'(FRAME_BITS));
    assign w_top_idx  = r_cnt - CNT_W'(1);
    assign w_stop_idx = r_cnt - CNT_W'(FRAME_BITS);
    assign w_top      = w_ge10 && r_buf[w_top_idx];
    assign w_stop     = r_buf[w_stop_idx];

    // first data bit sent sits just below the start bit
    always_comb begin
        for (int i = 0; i < DATA_W; i++) begin
            w_char[i] = r_buf[r_cnt - CNT_W'(2) - CNT_W'(i)];
        end
    end

    always_comb begin
        n_state = r_state;
        n_buf   = r_buf;
        n_cnt   = r_cnt;
        n_sreg  = r_sreg;
        n_left  = r_left;
        o_frame = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SHIFT;
                    if (i_operation == OP_BIT) begin
                        n_sreg = {i_line_bit, {(DATA_W-1){1'b0}}};
                        n_left = 3'd0;
                    end else begin
                        n_sreg = i_data_byte;
                        n_left = 3'd7;
                    end
                end
            end
            ST_SHIFT: begin
                n_buf  = {r_buf[BUF_W-2:0], r_sreg[DATA_W-1]};
                n_sreg = {r_sreg[DATA_W-2:0], 1'b0};
                n_cnt  = (r_cnt == CNT_W'(BUF_W)) ? r_cnt : r_cnt + CNT_W'(1);
                n_left = r_left - 3'd1;
                if (r_left == 3'd0) begin
                    n_state = ST_TRIM;
                end
            end
            ST_TRIM: begin
                if (w_top) begin
                    n_cnt = r_cnt - CNT_W'(1);
                end else if (w_ge10) begin
                    if (i_push_ok) begin
                        o_frame.valid             = 1'b1;
                        o_frame.frame.frame_error = !w_stop;
                        o_frame.frame.char_out    = w_stop ? w_char : '0;
                        n_cnt   = r_cnt - CNT_W'(FRAME_BITS);
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_idle = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_buf   <= '1;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_buf   <= n_buf;
            r_cnt   <= n_cnt;
        end
        r_sreg <= n_sreg;
        r_left <= n_left;
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(BUF_W))
        else $error("bit count above buffer width");

    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_cnt < CNT_W'(FRAME_BITS)))
        else $error("complete frame left in buffer while idle");

    a_emit_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame.valid |=> (r_state == ST_IDLE) && (r_cnt == $past(r_cnt) - CNT_W'(FRAME_BITS)))
        else $error("frame not consumed after emit");

endmodule

// File: design/ase_out_reg.sv
`timescale 1ns / 1ps

module ase_out_reg
    import ase_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_frame_beat i_frame,
    input  logic        i_ready,
    output logic        o_push_ok,
    output logic        o_valid,
    output t_frame      o_frame
);

    logic   r_valid, n_valid;
    t_frame r_frame;

    assign o_push_ok = !r_valid || i_ready;
    assign n_valid   = i_frame.valid || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_frame.valid) begin
            r_frame <= i_frame.frame;
        end
    end

    assign o_valid = r_valid;
    assign o_frame = r_frame;

endmodule
